[src/svm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants for the sparse vector merge ALU
// Holds the word formats, register indexes, mode and error codes.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int MaxNz     = 32;
    localparam int CntW      = $clog2(MaxNz + 1);
    localparam int AddrW     = $clog2(MaxNz);
    localparam int IdxW      = 16;
    localparam int FracBits  = 16;
    localparam int QDepth    = 2;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DOT = 2'd3
    } t_mode;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_ORDER = 2'd2;
    localparam logic [1:0] ERR_FULL  = 2'd3;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_LEN  = 1'b1;

    typedef struct packed {
        logic              vector_select;
        logic              has_element;
        logic [IdxW-1:0]   elem_index;
        logic signed [31:0] elem_value;
        logic              end_of_vector;
    } t_in_word;

    typedef struct packed {
        logic [IdxW-1:0]    out_index;
        logic signed [31:0] out_value;
        logic               last_result;
        logic               empty_result;
        logic [1:0]         load_error;
    } t_out_word;

    // classified word handed from front to back
    typedef struct packed {
        logic               store;     // write element to a store
        logic               sel_b;
        logic [IdxW-1:0]    index;
        logic signed [31:0] value;
        logic               run;       // both vectors ended: merge now
        logic [1:0]         err;       // sticky error at run time
    } t_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)       return 32'sh7fffffff;
        else if (x < -66'sd2147483648) return 32'sh80000000;
        else                           return x[31:0];
    endfunction

endpackage

[src/svm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_front: load checker
// Checks range, order and store capacity of loaded elements, tracks counts,
// end marks and the sticky error, and issues store and run commands.
// ----------------------------------------------------------------------------
module svm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  svm_pkg::t_in_word i_word,
    input  logic [16:0]      i_len,
    output logic             o_cmd_valid,
    output svm_pkg::t_cmd    o_cmd,
    output logic             o_running
);
    import svm_pkg::*;

    logic [CntW-1:0] r_cnt [2];
    logic [CntW-1:0] n_cnt [2];
    logic [1:0]      r_ended, n_ended;
    logic [16:0]     r_prev [2];
    logic [16:0]     n_prev [2];
    logic [1:0]      r_err, n_err;
    logic            sb;
    logic [1:0]      e;
    logic            run;

    assign sb = i_word.vector_select;

    always_comb begin
        n_cnt   = r_cnt;
        n_ended = r_ended;
        n_prev  = r_prev;
        n_err   = r_err;
        e       = ERR_NONE;
        run     = 1'b0;
        o_cmd_valid = 1'b0;
        o_cmd   = '0;
        o_cmd.sel_b = sb;
        o_cmd.index = i_word.elem_index;
        o_cmd.value = i_word.elem_value;
        if (i_valid && !r_ended[sb]) begin
            if (i_word.has_element && r_err == ERR_NONE) begin
                if ({1'b0, i_word.elem_index} >= i_len)
                    e = ERR_RANGE;
                else if (r_prev[sb] != '1 && {1'b0, i_word.elem_index} <= r_prev[sb])
                    e = ERR_ORDER;
                else if (i_word.elem_value != 0 && r_cnt[sb] >= CntW'(MaxNz))
                    e = ERR_FULL;
                if (e != ERR_NONE) begin
                    n_err = e;
                end else begin
                    n_prev[sb] = {1'b0, i_word.elem_index};
                    if (i_word.elem_value != 0) begin
                        o_cmd.store = 1'b1;
                        n_cnt[sb]   = r_cnt[sb] + 1'b1;
                    end
                end
            end
            if (i_word.end_of_vector) n_ended[sb] = 1'b1;
            run = n_ended == 2'b11;
            o_cmd.run = run;
            o_cmd.err = n_err;
            o_cmd_valid = o_cmd.store || run;
            if (run) begin
                n_cnt   = '{default: '0};
                n_ended = '0;
                n_prev  = '{default: '1};
                n_err   = ERR_NONE;
            end
        end
    end

    assign o_running = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '{default: '0};
            r_ended <= '0;
            r_prev  <= '{default: '1};
            r_err   <= ERR_NONE;
        end else begin
            r_cnt   <= n_cnt;
            r_ended <= n_ended;
            r_prev  <= n_prev;
            r_err   <= n_err;
        end
    end
endmodule

[src/svm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_queue: command queue
// Short FIFO of classified commands between the front and back parts.
// ----------------------------------------------------------------------------
module svm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  svm_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output svm_pkg::t_cmd  o_cmd,
    output logic           o_full
);
    import svm_pkg::*;

    localparam int PtrW = $clog2(QDepth);

    t_cmd            r_mem [QDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [PtrW:0]   r_cnt;

    assign o_valid = r_cnt != 0;
    assign o_full  = r_cnt == (PtrW+1)'(QDepth);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(i_push) - (PtrW+1)'(i_pop);
        end
    end
endmodule

[src/svm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_back: store and merge engine
// Writes elements into the A and B stores and walks both stores in index
// order for a merge run; each step is S_STEP (compare), then S_MUL (compute).
// ----------------------------------------------------------------------------
module svm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  svm_pkg::t_cmd     i_cmd,
    input  svm_pkg::t_mode    i_mode,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_res_valid,
    output svm_pkg::t_out_word o_res
);
    import svm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_STEP = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [IdxW-1:0]    r_a_idx [MaxNz];
    logic signed [31:0] r_a_val [MaxNz];
    logic [IdxW-1:0]    r_b_idx [MaxNz];
    logic signed [31:0] r_b_val [MaxNz];
    logic [CntW-1:0]    r_a_cnt, r_b_cnt;
    logic [CntW-1:0]    r_i, r_j;
    logic [IdxW-1:0]    r_ai, r_bi;
    logic signed [31:0] r_av, r_bv;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic               r_ta, r_tb;
    logic [IdxW-1:0]    r_oidx;
    logic [IdxW-1:0]    r_hold_idx;
    logic signed [31:0] r_hold_val;
    logic               r_any;
    t_mode              r_mode;

    logic a_ok, b_ok, ta, tb;
    logic signed [63:0] sh;
    logic signed [64:0] sum;
    logic signed [65:0] ev;
    logic signed [31:0] v;

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_valid && r_state == S_IDLE && i_cmd.store) begin
            if (i_cmd.sel_b) begin
                r_b_idx[r_b_cnt[AddrW-1:0]] <= i_cmd.index;
                r_b_val[r_b_cnt[AddrW-1:0]] <= i_cmd.value;
            end else begin
                r_a_idx[r_a_cnt[AddrW-1:0]] <= i_cmd.index;
                r_a_val[r_a_cnt[AddrW-1:0]] <= i_cmd.value;
            end
        end
        r_ai <= r_a_idx[r_i[AddrW-1:0]];
        r_av <= r_a_val[r_i[AddrW-1:0]];
        r_bi <= r_b_idx[r_j[AddrW-1:0]];
        r_bv <= r_b_val[r_j[AddrW-1:0]];
    end

    assign a_ok = r_i < r_a_cnt;
    assign b_ok = r_j < r_b_cnt;
    assign ta = a_ok && (!b_ok || r_ai <= r_bi);
    assign tb = b_ok && (!a_ok || r_bi <= r_ai);
    assign sh = r_prod >>> FracBits;
    assign sum = {sh[63], sh} + {r_acc[63], r_acc};

    always_comb begin
        case (r_mode)
            MODE_SUB: ev = 66'(r_ta ? r_av : 32'sd0) - 66'(r_tb ? r_bv : 32'sd0);
            MODE_MUL: ev = (r_ta && r_tb) ? 66'(sh) : 66'sd0;
            default:  ev = 66'(r_ta ? r_av : 32'sd0) + 66'(r_tb ? r_bv : 32'sd0);
        endcase
        v = sat32(ev);
    end

    assign o_pop  = i_valid && r_state == S_IDLE;
    assign o_busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_a_cnt     <= '0;
            r_b_cnt     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_any       <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd.store) begin
                            if (i_cmd.sel_b) r_b_cnt <= r_b_cnt + 1'b1;
                            else             r_a_cnt <= r_a_cnt + 1'b1;
                        end
                        if (i_cmd.run) begin
                            r_mode <= i_mode;
                            r_i <= '0;
                            r_j <= '0;
                            r_any <= 1'b0;
                            r_acc <= '0;
                            if (i_cmd.store) begin
                                if (i_cmd.sel_b) r_b_cnt <= r_b_cnt + 1'b1;
                                else             r_a_cnt <= r_a_cnt + 1'b1;
                            end
                            if (i_cmd.err != ERR_NONE) begin
                                o_res_valid <= 1'b1;
                                o_res <= '{out_index: '0, out_value: '0, last_result: 1'b1,
                                           empty_result: 1'b1, load_error: i_cmd.err};
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_READ: r_state <= S_STEP;
                S_STEP: begin
                    if (r_mode == MODE_DOT ? (a_ok && b_ok) : (a_ok || b_ok)) begin
                        r_ta <= ta;
                        r_tb <= tb;
                        r_oidx <= ta ? r_ai : r_bi;
                        r_prod <= r_av * r_bv;
                        if (ta) r_i <= r_i + 1'b1;
                        if (tb) r_j <= r_j + 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        o_res_valid <= 1'b1;
                        if (r_mode == MODE_DOT)
                            o_res <= '{out_index: '0, out_value: sat32(66'(r_acc)),
                                       last_result: 1'b1, empty_result: 1'b0,
                                       load_error: ERR_NONE};
                        else if (r_any)
                            o_res <= '{out_index: r_hold_idx, out_value: r_hold_val,
                                       last_result: 1'b1, empty_result: 1'b0,
                                       load_error: ERR_NONE};
                        else
                            o_res <= '{out_index: '0, out_value: '0, last_result: 1'b1,
                                       empty_result: 1'b1, load_error: ERR_NONE};
                        r_state <= S_DONE;
                    end
                end
                S_MUL: begin
                    // finish step; non-dot results are held one step so the
                    // final one can carry the last mark
                    if (r_mode == MODE_DOT) begin
                        if (r_ta && r_tb) begin
                            if (sum > 65'sh0_7fff_ffff_ffff_ffff)
                                r_acc <= 64'sh7fff_ffff_ffff_ffff;
                            else if (sum < -65'sh0_8000_0000_0000_0000)
                                r_acc <= 64'sh8000_0000_0000_0000;
                            else
                                r_acc <= sum[63:0];
                        end
                    end else if (v != 0) begin
                        if (r_any) begin
                            o_res_valid <= 1'b1;
                            o_res <= '{out_index: r_hold_idx, out_value: r_hold_val,
                                       last_result: 1'b0, empty_result: 1'b0,
                                       load_error: ERR_NONE};
                        end
                        r_any      <= 1'b1;
                        r_hold_idx <= r_oidx;
                        r_hold_val <= v;
                    end
                    // store reads for the new pointers land by the next cycle
                    r_state <= S_STEP;
                end
                S_DONE: begin
                    r_a_cnt <= '0;
                    r_b_cnt <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[src/sparse_vector_merge_alu_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_vector_merge_alu_top: sparse vector add / subtract / product / dot
// Loads two sparse Q16.16 vectors and merges them by index in a chosen mode.
// ----------------------------------------------------------------------------
// Loading: start is honored whenever busy is low. A word that is ignored or
// carries a zero value queues no store command; a word whose element is
// stored holds busy high while its store command sits in the queue.
// After both vectors are ended, a merge run walks both 32-entry stores, each
// merge step a store read, then an add or multiply; busy is high for the run.
// Results appear with o_res_valid for one cycle each; the receiver cannot
// stall them. The error item or the empty marker is a single word with
// last_result set.
// Registers (APB): 0x0 mode, 0x4 vector_length; write only while idle.
// ----------------------------------------------------------------------------
module sparse_vector_merge_alu_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  svm_pkg::t_in_word    i_word,
    output logic                 o_res_valid,
    output svm_pkg::t_out_word   o_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import svm_pkg::*;

    t_mode       r_mode;
    logic [16:0] r_len;
    logic        wr;
    logic        cmd_valid, q_valid, q_full, pop, back_busy, running;
    t_cmd        cmd, q_cmd;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ADD;
            r_len  <= 17'h10000;
        end else if (wr) begin
            case (paddr[2])
                REG_MODE: r_mode <= t_mode'(pwdata[1:0]);
                REG_LEN:  r_len  <= pwdata[16:0];
                default:  ;
            endcase
        end
    end

    assign prdata = paddr[2] == REG_LEN ? {15'd0, r_len} : {30'd0, r_mode};

    // hold off new words while a command is queued or a run is active
    assign busy = q_full || back_busy || q_valid || running;

    svm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_word      (i_word),
        .i_len       (r_len),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .o_running   (running)
    );

    svm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_full  (q_full)
    );

    svm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .i_mode      (r_mode),
        .o_pop       (pop),
        .o_busy      (back_busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );
endmodule

[sim/tb_sparse_vector_merge_alu_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_vector_merge_alu_top: self-checking bench for the sparse merge ALU
// Loads random and directed sparse vector pairs under all four modes and
// several vector lengths. A local model of the merge predicts every result
// word, and a checker compares each o_res word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sparse_vector_merge_alu_top;
    import svm_pkg::*;

    localparam int WdogLimit = 4000;
    localparam logic [16:0] PrevNone = 17'h1ffff;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_word;
    logic        o_res_valid;
    t_out_word   o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sparse_vector_merge_alu_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_word     (i_word),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Merge model state: one copy of the stores per vector (0 = A, 1 = B)
    // ------------------------------------------------------------------------
    t_mode              cfg_mode;
    logic [16:0]        cfg_len;
    logic [15:0]        nz_index [2][MaxNz];
    logic signed [31:0] nz_value [2][MaxNz];
    int                 nz_count [2];
    bit                 vec_done [2];
    logic [16:0]        last_index [2];
    logic [1:0]         first_err;

    t_out_word expected_words[$];

    int  n_fail;
    int  n_words_in;
    int  n_words_out;
    int  n_runs;
    int  n_err_runs;
    bit  no_gaps;

    function automatic void clear_vectors();
        for (int s = 0; s < 2; s++) begin
            nz_count[s]   = 0;
            vec_done[s]   = 1'b0;
            last_index[s] = PrevNone;
        end
        first_err = ERR_NONE;
    endfunction

    // Q16.16 product, floor shift (arithmetic shift on a signed 64-bit value)
    function automatic longint qmul(logic signed [31:0] x, logic signed [31:0] y);
        longint p;
        p = longint'(x) * longint'(y);
        return p >>> FracBits;
    endfunction

    function automatic logic signed [31:0] clip32(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint acc_add(longint x, longint y);
        longint s;
        s = x + y;
        if (x > 0 && y > 0 && s < 0) return 64'sh7fffffffffffffff;
        if (x < 0 && y < 0 && s >= 0) return 64'sh8000000000000000;
        return s;
    endfunction

    function automatic t_out_word make_word(logic [15:0] idx, logic signed [31:0] val,
                                            logic last, logic empty, logic [1:0] err);
        t_out_word w;
        w.out_index    = idx;
        w.out_value    = val;
        w.last_result  = last;
        w.empty_result = empty;
        w.load_error   = err;
        return w;
    endfunction

    function automatic void merge_run();
        int        i;
        int        j;
        longint    acc;
        bit        ta;
        bit        tb;
        logic [15:0] idx;
        logic signed [31:0] va;
        logic signed [31:0] vb;
        logic signed [31:0] v;
        t_out_word run_q[$];
        i = 0;
        j = 0;
        n_runs++;
        if (first_err != ERR_NONE) begin
            n_err_runs++;
            expected_words.push_back(make_word(16'd0, 32'sd0, 1'b1, 1'b1, first_err));
            return;
        end
        if (cfg_mode == MODE_DOT) begin
            acc = 0;
            while (i < nz_count[0] && j < nz_count[1]) begin
                if (nz_index[0][i] == nz_index[1][j]) begin
                    acc = acc_add(acc, qmul(nz_value[0][i], nz_value[1][j]));
                    i++;
                    j++;
                end else if (nz_index[0][i] < nz_index[1][j]) begin
                    i++;
                end else begin
                    j++;
                end
            end
            expected_words.push_back(make_word(16'd0, clip32(acc), 1'b1, 1'b0, ERR_NONE));
            return;
        end
        while (i < nz_count[0] || j < nz_count[1]) begin
            ta  = i < nz_count[0] && (j >= nz_count[1] || nz_index[0][i] <= nz_index[1][j]);
            tb  = j < nz_count[1] && (i >= nz_count[0] || nz_index[1][j] <= nz_index[0][i]);
            idx = ta ? nz_index[0][i] : nz_index[1][j];
            va  = ta ? nz_value[0][i] : 32'sd0;
            vb  = tb ? nz_value[1][j] : 32'sd0;
            case (cfg_mode)
                MODE_MUL: v = (ta && tb) ? clip32(qmul(va, vb)) : 32'sd0;
                MODE_SUB: v = clip32(longint'(va) - longint'(vb));
                default:  v = clip32(longint'(va) + longint'(vb));
            endcase
            if (ta) i++;
            if (tb) j++;
            if (v != 0) run_q.push_back(make_word(idx, v, 1'b0, 1'b0, ERR_NONE));
        end
        if (run_q.size() == 0) begin
            expected_words.push_back(make_word(16'd0, 32'sd0, 1'b1, 1'b1, ERR_NONE));
            return;
        end
        run_q[run_q.size()-1].last_result = 1'b1;
        foreach (run_q[k]) expected_words.push_back(run_q[k]);
    endfunction

    // Model of one accepted input word
    function automatic void predict_word(t_in_word w);
        int         s;
        logic [1:0] err;
        s = w.vector_select;
        if (vec_done[s]) return;
        if (w.has_element && first_err == ERR_NONE) begin
            err = ERR_NONE;
            if ({1'b0, w.elem_index} >= cfg_len)
                err = ERR_RANGE;
            else if (last_index[s] != PrevNone && {1'b0, w.elem_index} <= last_index[s])
                err = ERR_ORDER;
            else if (w.elem_value != 0 && nz_count[s] >= MaxNz)
                err = ERR_FULL;
            if (err != ERR_NONE) begin
                first_err = err;
            end else begin
                last_index[s] = {1'b0, w.elem_index};
                if (w.elem_value != 0) begin
                    nz_index[s][nz_count[s]] = w.elem_index;
                    nz_value[s][nz_count[s]] = w.elem_value;
                    nz_count[s]++;
                end
            end
        end
        if (w.end_of_vector) vec_done[s] = 1'b1;
        if (vec_done[0] && vec_done[1]) begin
            merge_run();
            clear_vectors();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------------
    int idle_cycles;

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_res_valid) begin
            n_words_out++;
            if (expected_words.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected result word: expected none, actual %h", $time, o_res);
            end else begin
                e = expected_words.pop_front();
                if (o_res.out_index !== e.out_index || o_res.out_value !== e.out_value ||
                    o_res.last_result !== e.last_result ||
                    o_res.empty_result !== e.empty_result ||
                    o_res.load_error !== e.load_error) begin
                    n_fail++;
                    $display("%0t: mismatch: expected idx=%0d val=%h last=%b empty=%b err=%0d",
                             $time, e.out_index, e.out_value, e.last_result,
                             e.empty_result, e.load_error);
                    $display("%0t:           actual   idx=%0d val=%h last=%b empty=%b err=%0d",
                             $time, o_res.out_index, o_res.out_value, o_res.last_result,
                             o_res.empty_result, o_res.load_error);
                end
            end
        end
    end

    // Any accepted word in either direction keeps the watchdog quiet
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WdogLimit) begin
                $display("sparse_vector_merge_alu_top verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one word, hold start across back-to-back words, drop it for gaps
    task automatic send_word(t_in_word w);
        int g;
        i_word <= w;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_words_in++;
        predict_word(w);
        g = gap_len();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_item(bit sel_b, bit has, int idx, logic [31:0] val, bit eov);
        t_in_word w;
        w.vector_select = sel_b;
        w.has_element   = has;
        w.elem_index    = idx[15:0];
        w.elem_value    = val;
        w.end_of_vector = eov;
        send_word(w);
    endtask

    // Wait for all results and for busy to drop, then idle before returning
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0 || busy);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_check(logic [2:0] addr, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            n_fail++;
            $display("%0t: register read at %h: expected %h, actual %h",
                     $time, addr, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reconfigure only with the block idle and both vectors empty
    task automatic configure(t_mode m, int len);
        wait_idle();
        reg_write(3'h0, {30'd0, m});
        reg_write(3'h4, len);
        cfg_mode = m;
        cfg_len  = len[16:0];
        reg_check(3'h0, {30'd0, m});
        reg_check(3'h4, {15'd0, cfg_len});
    endtask

    // ------------------------------------------------------------------------
    // Random vector pairs
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_value(bit nonzero);
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 9);
        case (r)
            0:       v = 32'd0;
            1:       v = 32'h7fffffff;
            2:       v = 32'h80000000;
            3, 4:    v = $urandom_range(0, 32'h3ffff) - 32'h20000;
            default: v = $urandom;
        endcase
        if (nonzero && v == 0) v = 32'h00010000;
        return v;
    endfunction

    // Build one vector as a word list; err_kind injects a load error
    task automatic build_vector(bit sel_b, int n, int span, logic [1:0] err_kind,
                                ref t_in_word q[$]);
        t_in_word w;
        int       cur;
        int       lim;
        lim = cfg_len;
        cur = (lim > span * 40 && $urandom_range(0, 2) == 0) ?
              $urandom_range(0, lim - 1 - span * 40) : $urandom_range(0, span - 1);
        w.vector_select = sel_b;
        for (int k = 0; k < n && cur < lim; k++) begin
            w.has_element   = 1'b1;
            w.elem_index    = cur[15:0];
            w.elem_value    = pick_value(err_kind == ERR_FULL);
            w.end_of_vector = 1'b0;
            q.push_back(w);
            // an occasional word with neither element nor end mark
            if ($urandom_range(0, 19) == 0) begin
                w.has_element = 1'b0;
                q.push_back(w);
            end
            cur += (err_kind == ERR_FULL) ? 1 : $urandom_range(1, span);
        end
        w.has_element = 1'b1;
        if (err_kind == ERR_RANGE && lim < 65536) begin
            w.elem_index = $urandom_range(lim, 65535);
            w.elem_value = pick_value(1'b1);
            q.push_back(w);
        end else if (err_kind == ERR_ORDER && q.size() > 0) begin
            w.elem_index = q[q.size()-1].elem_index - $urandom_range(0, 1);
            w.elem_value = pick_value(1'b0);
            q.push_back(w);
        end
        if (err_kind != ERR_NONE) begin
            // elements after an error are dropped by the block
            w.elem_index = $urandom;
            w.elem_value = $urandom;
            q.push_back(w);
        end
        if (q.size() > 0 && $urandom_range(0, 1) == 0) begin
            q[q.size()-1].end_of_vector = 1'b1;
        end else begin
            w.has_element   = 1'b0;
            w.elem_index    = $urandom;
            w.elem_value    = $urandom;
            w.end_of_vector = 1'b1;
            q.push_back(w);
        end
    endtask

    task automatic send_pair(int na, int nb, int span, logic [1:0] err_kind);
        t_in_word qa[$];
        t_in_word qb[$];
        t_in_word w;
        bit       take_b;
        bit       err_b;
        err_b = $urandom_range(0, 1);
        build_vector(1'b0, na, span, err_b ? ERR_NONE : err_kind, qa);
        build_vector(1'b1, nb, span, err_b ? err_kind : ERR_NONE, qb);
        while (qa.size() > 0 || qb.size() > 0) begin
            take_b = (qa.size() == 0) || (qb.size() > 0 && $urandom_range(0, 1));
            w = take_b ? qb.pop_front() : qa.pop_front();
            send_word(w);
            // a stray word for a vector that already ended is ignored
            if (w.end_of_vector && (qa.size() > 0 || qb.size() > 0) &&
                $urandom_range(0, 3) == 0) begin
                w.has_element   = $urandom;
                w.elem_index    = $urandom;
                w.elem_value    = $urandom;
                w.end_of_vector = $urandom;
                send_word(w);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_registers();
        configure(MODE_DOT, 1);
        configure(MODE_MUL, 65536);
    endtask

    // Saturation at both rails, cancellation, empty vectors, both products
    task automatic test_directed_arith();
        configure(MODE_ADD, 65536);
        send_item(0, 1, 0, 32'h7fffffff, 0);
        send_item(1, 1, 0, 32'h00000001, 0);
        send_item(0, 1, 65535, 32'h80000000, 1);
        send_item(1, 1, 65535, 32'hffffffff, 1);
        configure(MODE_SUB, 65536);
        send_item(0, 1, 3, 32'h00050000, 1);
        send_item(1, 1, 3, 32'h00050000, 1);
        send_item(1, 0, 0, 32'h0, 1);
        send_item(0, 0, 0, 32'h0, 1);
        configure(MODE_MUL, 65536);
        send_item(0, 1, 1, 32'h00010000, 0);
        send_item(1, 1, 2, 32'h7fffffff, 0);
        send_item(0, 1, 2, 32'h7fffffff, 1);
        send_item(1, 1, 7, 32'h00000004, 1);
        configure(MODE_DOT, 65536);
        send_item(0, 1, 0, 32'h80000000, 1);
        send_item(1, 1, 0, 32'h80000000, 1);
        send_item(0, 1, 1, 32'h00050000, 1);
        send_item(1, 1, 2, 32'h00050000, 1);
    endtask

    // Range, order (also after a zero element), and a clean run after the errors
    task automatic test_directed_errors();
        configure(MODE_ADD, 10);
        send_item(0, 1, 10, 32'h1, 0);
        send_item(0, 1, 2, 32'h1, 1);
        send_item(1, 0, 0, 32'h0, 1);
        send_item(1, 1, 4, 32'h1, 0);
        send_item(1, 1, 4, 32'h2, 1);
        send_item(0, 0, 0, 32'h0, 1);
        send_item(0, 1, 5, 32'h0, 0);
        send_item(0, 1, 5, 32'h1, 1);
        send_item(1, 1, 9, 32'h3, 1);
        send_item(1, 1, 1, 32'h1, 1);
        send_item(0, 1, 9, 32'h1, 1);
    endtask

    task automatic test_random_runs(int n_items);
        int stop_at;
        int lens[4];
        int r;
        logic [1:0] ek;
        lens = '{65536, 1, 40, 1000};
        stop_at = n_words_in + n_items;
        for (int phase = 0; n_words_in < stop_at; phase++) begin
            configure(t_mode'(phase % 4), (phase % 5 == 4) ? $urandom_range(2, 65536)
                                                           : lens[(phase / 4) % 4]);
            for (int k = 0; k < 4; k++) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                r  = $urandom_range(0, 9);
                ek = (r == 0) ? ERR_RANGE : (r == 1) ? ERR_ORDER : ERR_NONE;
                if (r == 2 && cfg_len >= 40) begin
                    send_pair(33, $urandom_range(0, 4), 1, ERR_FULL);
                end else begin
                    send_pair($urandom_range(0, 12), $urandom_range(0, 12),
                              $urandom_range(1, 4) * (r > 7 ? 4000 : 1), ek);
                end
            end
            no_gaps = 1'b0;
        end
    endtask

    // The sender holds off until every predicted word has come back
    task automatic test_drain_pause();
        send_pair(6, 6, 2, ERR_NONE);
        start <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
        send_pair(MaxNz, MaxNz, 1, ERR_NONE);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_word      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        n_fail      = 0;
        n_words_in  = 0;
        n_words_out = 0;
        n_runs      = 0;
        n_err_runs  = 0;
        no_gaps     = 1'b0;
        idle_cycles = 0;
        cfg_mode    = MODE_ADD;
        cfg_len     = 17'd65536;
        clear_vectors();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_arith();
        test_directed_errors();
        test_registers();
        test_drain_pause();
        test_random_runs(350);

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d input words and %0d result words over %0d merge runs",
                 n_words_in, n_words_out, n_runs);
        $display("(%0d of them with a load error), all four modes and several lengths.",
                 n_err_runs);
        if (n_fail == 0 && expected_words.size() == 0) begin
            $display("sparse_vector_merge_alu_top verification clean");
        end else begin
            $display("%0t: %0d failures, %0d expected words never came",
                     $time, n_fail, expected_words.size());
            $display("sparse_vector_merge_alu_top verification failed");
        end
        $finish;
    end

endmodule
